/* hdl/matrix_multiply_unit_defines.svh */
// Assertion macros used by mmu_seq.
`ifndef MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MMU_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mmu: same-cycle check failed");
`define MMU_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mmu: next-cycle check failed");
`else
`define MMU_ASSERT_SAME(name, clk, rstn, ante, cons)
`define MMU_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

/* hdl/mmu_pkg.sv */
package mmu_pkg;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned SIZE_W  = 6;
    localparam int unsigned ELEM_W  = 16;
    localparam int unsigned PROD_W  = 32;
    localparam int unsigned ACC_W   = 38;
    localparam int unsigned CFG_A_W = 2;

    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [CFG_A_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_INNER_SIZE   = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_COL_COUNT    = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_B_TRANSPOSED = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    typedef struct packed {
        logic [SIZE_W-1:0] row_count;
        logic [SIZE_W-1:0] inner_size;
        logic [SIZE_W-1:0] col_count;
        logic              b_transposed;
    } cfg_t;

endpackage

/* hdl/mmu_ram.sv */
module mmu_ram #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10
) (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [ADDR_W-1:0]               waddr,
    input  logic [mmu_pkg::ELEM_W-1:0]      wdata,
    input  logic                            re,
    input  logic [ADDR_W-1:0]               raddr,
    output logic [mmu_pkg::ELEM_W-1:0]      rdata
);

    logic [mmu_pkg::ELEM_W-1:0] mem [DEPTH];
    logic [mmu_pkg::ELEM_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/mmu_cfg.sv */
module mmu_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mmu_pkg::CFG_A_W-1:0]      cfg_addr,
    input  logic [mmu_pkg::SIZE_W-1:0]       cfg_wdata,
    output mmu_pkg::cfg_t                    cfg
);

    logic [mmu_pkg::SIZE_W-1:0] row_count_reg;
    logic [mmu_pkg::SIZE_W-1:0] inner_size_reg;
    logic [mmu_pkg::SIZE_W-1:0] col_count_reg;
    logic                       b_transposed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= mmu_pkg::SIZE_RESET;
            inner_size_reg   <= mmu_pkg::SIZE_RESET;
            col_count_reg    <= mmu_pkg::SIZE_RESET;
            b_transposed_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mmu_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_wdata;
                mmu_pkg::REG_INNER_SIZE:   inner_size_reg   <= cfg_wdata;
                mmu_pkg::REG_COL_COUNT:    col_count_reg    <= cfg_wdata;
                mmu_pkg::REG_B_TRANSPOSED: b_transposed_reg <= cfg_wdata[0];
            endcase
        end
    end

    assign cfg.row_count    = row_count_reg;
    assign cfg.inner_size   = inner_size_reg;
    assign cfg.col_count    = col_count_reg;
    assign cfg.b_transposed = b_transposed_reg;

endmodule

/* hdl/mmu_seq.sv */
`include "matrix_multiply_unit_defines.svh"

module mmu_seq #(
    parameter int unsigned MAX_DIM = 32,
    parameter int unsigned ADDR_W  = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mmu_pkg::cfg_t                       cfg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mmu_pkg::OP_W-1:0]            s_operation,
    input  logic [mmu_pkg::IDX_W-1:0]           s_row_index,
    input  logic [mmu_pkg::IDX_W-1:0]           s_col_index,
    input  logic signed [mmu_pkg::ELEM_W-1:0]   s_element_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mmu_pkg::ACC_W-1:0]    m_product_value,
    output logic                                m_status,
    output logic                                a_we,
    output logic                                b_we,
    output logic [ADDR_W-1:0]                   waddr,
    output logic [mmu_pkg::ELEM_W-1:0]          wdata,
    output logic                                rd_en,
    output logic [ADDR_W-1:0]                   a_raddr,
    output logic [ADDR_W-1:0]                   b_raddr,
    input  logic [mmu_pkg::ELEM_W-1:0]          a_rdata,
    input  logic [mmu_pkg::ELEM_W-1:0]          b_rdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

    localparam int unsigned SW = mmu_pkg::SIZE_W;

    function automatic logic [ADDR_W-1:0] slot(input logic [SW-1:0] r, input logic [SW-1:0] c);
        logic [31:0] s;
        s = 32'(r) * 32'(MAX_DIM) + 32'(c);
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic in_dim(input logic [SW-1:0] idx, input logic [SW-1:0] size);
        return (idx < size) && ({3'b000, idx} < 9'(MAX_DIM));
    endfunction

    state_t                               state_reg;
    logic [SW-1:0]                        t_reg;
    logic [SW-1:0]                        k_reg;
    logic [mmu_pkg::IDX_W-1:0]            row_reg;
    logic [mmu_pkg::IDX_W-1:0]            col_reg;
    logic                                 rd_vld_reg;
    logic                                 prod_vld_reg;
    logic signed [mmu_pkg::PROD_W-1:0]    prod_reg;
    logic signed [mmu_pkg::ACC_W-1:0]     acc_reg;
    logic                                 m_valid_reg;
    logic signed [mmu_pkg::ACC_W-1:0]     m_product_reg;
    logic                                 m_status_reg;

    logic              out_free;
    logic              out_load;
    logic              in_fire;
    logic              imm_status;
    logic              start_read;
    logic              a_ok;
    logic              b_ok;
    logic              rd_ok;
    logic [SW-1:0]     row_ext;
    logic [SW-1:0]     col_ext;
    logic [SW-1:0]     b_rlim;
    logic [SW-1:0]     b_clim;
    logic [SW-1:0]     k_cap;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_valid && s_ready;
    assign out_load = (in_fire && !start_read) || ((state_reg == ST_DONE) && out_free);

    assign row_ext = {1'b0, s_row_index};
    assign col_ext = {1'b0, s_col_index};
    assign b_rlim  = cfg.b_transposed ? cfg.col_count : cfg.inner_size;
    assign b_clim  = cfg.b_transposed ? cfg.inner_size : cfg.col_count;
    assign a_ok    = in_dim(row_ext, cfg.row_count) && in_dim(col_ext, cfg.inner_size);
    assign b_ok    = in_dim(row_ext, b_rlim) && in_dim(col_ext, b_clim);
    assign rd_ok   = in_dim(row_ext, cfg.row_count) && in_dim(col_ext, cfg.col_count);
    assign k_cap   = ({3'b000, cfg.inner_size} > 9'(MAX_DIM)) ? SW'(MAX_DIM) : cfg.inner_size;

    always_comb begin
        a_we       = 1'b0;
        b_we       = 1'b0;
        start_read = 1'b0;
        imm_status = 1'b1;
        unique case (s_operation)
            mmu_pkg::OP_WRITE_A: begin
                a_we       = in_fire && a_ok;
                imm_status = !a_ok;
            end
            mmu_pkg::OP_WRITE_B: begin
                b_we       = in_fire && b_ok;
                imm_status = !b_ok;
            end
            mmu_pkg::OP_READ: begin
                start_read = in_fire && rd_ok;
                imm_status = !rd_ok;
            end
            default: begin
                imm_status = 1'b1;
            end
        endcase
    end

    assign waddr   = slot(row_ext, col_ext);
    assign wdata   = s_element_value;
    assign rd_en   = (state_reg == ST_RUN);
    assign a_raddr = slot({1'b0, row_reg}, t_reg);
    assign b_raddr = cfg.b_transposed ? slot({1'b0, col_reg}, t_reg)
                                      : slot(t_reg, {1'b0, col_reg});

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(a_rdata) * $signed(b_rdata);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_vld_reg   <= rd_en;
            prod_vld_reg <= rd_vld_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (prod_vld_reg) begin
                acc_reg <= acc_reg + {{(mmu_pkg::ACC_W - mmu_pkg::PROD_W){prod_reg[31]}}, prod_reg};
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (start_read) begin
                        row_reg   <= s_row_index;
                        col_reg   <= s_col_index;
                        t_reg     <= '0;
                        k_reg     <= k_cap;
                        acc_reg   <= '0;
                        state_reg <= (k_cap == '0) ? ST_DONE : ST_RUN;
                    end else if (in_fire) begin
                        m_product_reg <= '0;
                        m_status_reg  <= imm_status;
                    end
                end
                ST_RUN: begin
                    t_reg <= t_reg + 1'b1;
                    if (t_reg == k_reg - 1'b1) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!rd_vld_reg && !prod_vld_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_product_reg <= acc_reg;
                        m_status_reg  <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_product_value = m_product_reg;
    assign m_status        = m_status_reg;

    `MMU_ASSERT_NEXT(a_rd_to_prod, aclk, aresetn, rd_vld_reg, prod_vld_reg)
    `MMU_ASSERT_SAME(a_idle_empty, aclk, aresetn, state_reg == ST_IDLE, !rd_vld_reg && !prod_vld_reg)
    `MMU_ASSERT_SAME(a_run_bound, aclk, aresetn, state_reg == ST_RUN, t_reg < k_reg)
    `MMU_ASSERT_SAME(a_we_on_fire, aclk, aresetn, a_we || b_we, in_fire && !start_read)

endmodule

/* hdl/matrix_multiply_unit.sv */
// Matrix multiply engine, C = A x B, signed Q8.8 elements, Q22.16 results.
// Input channel (s_*): one word per handshake; s_operation selects write A,
// write B or read C at (s_row_index, s_col_index). Result channel (m_*): one
// word per input word, m_product_value (zero for writes) and m_status
// (1 when the index lies outside the configured sizes or the operation is
// unknown). Configuration port: cfg_wr_en, cfg_addr, cfg_wdata; the user must
// write it only while no word is in flight, which the block does not enforce.
// Writes and rejected words: result valid in the cycle after acceptance; one
// word per cycle while the result side keeps up.
// Reads: the walk issues K A/B store read pairs, one per cycle, into a single
// multiply-accumulate (store read, product register, accumulator), K being
// inner_size capped at MAX_DIM (no walk when K is 0); the sum then goes to the
// output register, and the next word is taken only after it is loaded there.
// Reset: sizes return to 32 and b_transposed to 0; store contents are
// undefined until written, with no clearing pass.
// Stall: a result waits in the output register while m_ready is low; s_ready
// stays low until that register frees up.
module matrix_multiply_unit #(
    parameter int unsigned MAX_DIM = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mmu_pkg::CFG_A_W-1:0]         cfg_addr,
    input  logic [mmu_pkg::SIZE_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mmu_pkg::OP_W-1:0]            s_operation,
    input  logic [mmu_pkg::IDX_W-1:0]           s_row_index,
    input  logic [mmu_pkg::IDX_W-1:0]           s_col_index,
    input  logic signed [mmu_pkg::ELEM_W-1:0]   s_element_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mmu_pkg::ACC_W-1:0]    m_product_value,
    output logic                                m_status
);

    localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mmu_pkg::cfg_t                  cfg;
    logic                           a_we;
    logic                           b_we;
    logic [ADDR_W-1:0]              waddr;
    logic [mmu_pkg::ELEM_W-1:0]     wdata;
    logic                           rd_en;
    logic [ADDR_W-1:0]              a_raddr;
    logic [ADDR_W-1:0]              b_raddr;
    logic [mmu_pkg::ELEM_W-1:0]     a_rdata;
    logic [mmu_pkg::ELEM_W-1:0]     b_rdata;

    mmu_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mmu_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_a_store (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mmu_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_b_store (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mmu_seq #(.MAX_DIM(MAX_DIM), .ADDR_W(ADDR_W)) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_product_value (m_product_value),
        .m_status        (m_status),
        .a_we            (a_we),
        .b_we            (b_we),
        .waddr           (waddr),
        .wdata           (wdata),
        .rd_en           (rd_en),
        .a_raddr         (a_raddr),
        .b_raddr         (b_raddr),
        .a_rdata         (a_rdata),
        .b_rdata         (b_rdata)
    );

endmodule
